[sv/salc_pkg.sv]
`timescale 1ns / 1ps
package salc_pkg;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] RegOffBits = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSetBits = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWays = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWrBack = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWrAlloc = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHitTime = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMissPen = 3'd6;
  localparam logic [CfgIdxW-1:0] RegElemSize = 3'd7;
  localparam int unsigned MaxOffBits = 12;
  localparam int unsigned MaxSetBits = 8;
  localparam int unsigned CyclesW = 12;
  localparam int unsigned BytesW = 14;

  typedef struct packed {
    logic [3:0] off_bits;
    logic [3:0] set_bits;
    logic [3:0] ways_used;
    logic       wr_back;
    logic       write_alloc;
    logic [7:0] hit_time;
    logic [9:0] miss_penalty;
    logic [6:0] elem_size;
  } cfg_t;
endpackage

[sv/salc_cfg_regs.sv]
`timescale 1ns / 1ps
module salc_cfg_regs
  import salc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);
  cfg_t cfg_q;
  assign cfg_o = cfg_q;

  // register writes, truncated to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_bits     <= 4'd6;
      cfg_q.set_bits     <= 4'd4;
      cfg_q.ways_used    <= 4'd1;
      cfg_q.wr_back      <= 1'b1;
      cfg_q.write_alloc  <= 1'b1;
      cfg_q.hit_time     <= 8'd1;
      cfg_q.miss_penalty <= 10'd50;
      cfg_q.elem_size    <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOffBits:  cfg_q.off_bits     <= cfg_data_i[3:0];
        RegSetBits:  cfg_q.set_bits     <= cfg_data_i[3:0];
        RegWays:     cfg_q.ways_used    <= cfg_data_i[3:0];
        RegWrBack:   cfg_q.wr_back      <= cfg_data_i[0];
        RegWrAlloc:  cfg_q.write_alloc  <= cfg_data_i[0];
        RegHitTime:  cfg_q.hit_time     <= cfg_data_i[7:0];
        RegMissPen:  cfg_q.miss_penalty <= cfg_data_i[9:0];
        default:     cfg_q.elem_size    <= cfg_data_i[6:0];
      endcase
    end
  end
endmodule

[sv/set_assoc_lru_cache_model.sv]
`timescale 1ns / 1ps
// Tag-only set-associative cache model with LRU replacement.
// Slave channel s_axis_*: one access per item, tdata = {addr, op} with op at bit 0.
// Master channel m_axis_*: one result per access, tdata = {bytes_moved,
// access_cycles, dirty_evict, hit} with hit at bit 0.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, written while idle.
// The set's lines live in one memory row (all ways of a set side by side),
// read through a registered output, modified and written back.
// Each accepted item passes the read state (row read) and then the update
// state (update and write-back) before its result is registered. A new item
// is accepted only once the previous row has been written back and its
// result has been registered.
// After reset a clearing pass over all SETS rows zeroes valid, dirty and rank
// bits; no item is accepted during it.
// When the receiver stalls the result is held in the output register; the
// next item is taken meanwhile and waits after its lookup until the output
// register is free, and its result is registered once the held one is taken.
module set_assoc_lru_cache_model
  import salc_pkg::*;
#(
  parameter int unsigned WAYS = 8,
  parameter int unsigned SETS = 256,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // op, addr
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // hit, dirty_evict, access_cycles, bytes_moved
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WCntW = $clog2(WAYS + 1);
  localparam int unsigned RankW = WayW;
  localparam int unsigned TagW = ADDR_BITS;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [RankW-1:0] rank;
    logic [TagW-1:0]  tag;
  } line_t;
  typedef line_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {StClear, StIdle, StRead, StUpd} state_e;

  cfg_t cfg;
  salc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // row memory
  row_t mem [SETS];
  row_t rd_q;
  logic          mem_we;
  logic [SetW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic [SetW-1:0] rd_addr;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[rd_addr];
  end

  state_e state_q;
  logic [SetW-1:0] clr_q;
  logic            op_q;
  logic [TagW-1:0] tag_q;
  logic [SetW-1:0] set_q;
  logic [WCntW-1:0] ways_q;
  logic [12:0]     off_sh_q;
  logic            mv_q;
  logic [31:0]     mdata_q;

  // address decode of the incoming item
  logic [3:0]  off_s, sib_s;
  logic [ADDR_BITS-1:0] addr_s;
  logic [ADDR_BITS-1:0] sh_addr;
  logic [SetW-1:0] set_s;
  logic [7:0]  set_full;
  logic [WCntW-1:0] ways_s;
  always_comb begin
    off_s = (cfg.off_bits > 4'(MaxOffBits)) ? 4'(MaxOffBits) : cfg.off_bits;
    sib_s = (cfg.set_bits > 4'(MaxSetBits)) ? 4'(MaxSetBits) : cfg.set_bits;
    addr_s = ADDR_BITS'(s_axis_tdata[32:1]);
    sh_addr = addr_s >> off_s;
    set_full = sh_addr[7:0] & 8'((9'd1 << sib_s) - 9'd1);
    set_s = SetW'(32'(set_full) % SETS);
    if (cfg.ways_used == 4'd0) ways_s = WCntW'(1);
    else if (32'(cfg.ways_used) > WAYS) ways_s = WCntW'(WAYS);
    else ways_s = WCntW'(cfg.ways_used);
  end

  assign s_axis_tready = (state_q == StIdle);
  assign rd_addr = (state_q == StIdle) ? set_s : set_q;

  // lookup and update of the row
  logic hit, devict, found_inv;
  logic [WayW-1:0] hw, vw, invw, lruw, tw;
  logic [RankW-1:0] old;
  logic old_none;
  row_t nrow;
  logic [CyclesW+1:0] cyc;
  logic [BytesW+1:0] byt;
  logic do_fill;
  always_comb begin
    hit = 1'b0; hw = '0; found_inv = 1'b0; invw = '0; lruw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (WCntW'(w) < ways_q) begin
        if (rd_q[w].valid && rd_q[w].tag == tag_q) begin
          hit = 1'b1; hw = WayW'(w);
        end
        if (!rd_q[w].valid) begin
          found_inv = 1'b1; invw = WayW'(w);
        end
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (WCntW'(w) < ways_q && rd_q[w].rank > rd_q[lruw].rank) lruw = WayW'(w);
    end
    vw = found_inv ? invw : lruw;
    do_fill = !hit && !(op_q && !cfg.write_alloc);
    tw = hit ? hw : vw;
    old = rd_q[tw].rank;
    old_none = !rd_q[tw].valid;
    devict = do_fill && rd_q[vw].valid && rd_q[vw].dirty;
    cyc = (CyclesW+2)'(cfg.hit_time);
    byt = '0;
    nrow = rd_q;
    if (hit) begin
      if (op_q) begin
        if (cfg.wr_back) nrow[hw].dirty = 1'b1;
        else begin
          cyc = cyc + (CyclesW+2)'(cfg.miss_penalty);
          byt = byt + (BytesW+2)'(cfg.elem_size);
        end
      end
    end else begin
      cyc = cyc + (CyclesW+2)'(cfg.miss_penalty);
      if (!do_fill) byt = byt + (BytesW+2)'(cfg.elem_size);
      else begin
        if (devict) begin
          byt = byt + (BytesW+2)'(off_sh_q);
          cyc = cyc + (CyclesW+2)'(cfg.miss_penalty);
        end
        byt = byt + (BytesW+2)'(off_sh_q);
        nrow[vw].valid = 1'b1;
        nrow[vw].tag = tag_q;
        if (op_q && cfg.wr_back) nrow[vw].dirty = 1'b1;
        else begin
          nrow[vw].dirty = 1'b0;
          if (op_q) begin
            byt = byt + (BytesW+2)'(cfg.elem_size);
            cyc = cyc + (CyclesW+2)'(cfg.miss_penalty);
          end
        end
      end
    end
    // age younger valid ways, then make the touched way most recent
    if (hit || do_fill) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WCntW'(w) < ways_q && WayW'(w) != tw && rd_q[w].valid &&
            (old_none || rd_q[w].rank < old) && 32'(rd_q[w].rank) < WAYS - 1)
          nrow[w].rank = rd_q[w].rank + RankW'(1);
      end
      nrow[tw].rank = '0;
    end
  end

  always_comb begin
    mem_we = 1'b0; mem_waddr = set_q; mem_wdata = nrow;
    if (state_q == StClear) begin
      mem_we = 1'b1; mem_waddr = clr_q; mem_wdata = '0;
    end else if (state_q == StUpd && !mv_q) begin
      mem_we = 1'b1;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = mdata_q;

  // control sequence and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      mv_q <= 1'b0;
    end else begin
      if (mv_q && m_axis_tready) mv_q <= 1'b0;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + SetW'(1);
          if (32'(clr_q) == SETS - 1) state_q <= StIdle;
        end
        StIdle: if (s_axis_tvalid) state_q <= StRead;
        StRead: state_q <= StUpd;
        StUpd: if (!mv_q || m_axis_tready) begin
          if (!mv_q) begin
            mv_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      op_q <= s_axis_tdata[0];
      set_q <= set_s;
      tag_q <= TagW'(addr_s >> ({1'b0, off_s} + {1'b0, sib_s}));
      ways_q <= ways_s;
      off_sh_q <= 13'd1 << off_s;
    end
    if (state_q == StUpd && !mv_q) begin
      mdata_q <= {4'b0000, byt[BytesW-1:0], cyc[CyclesW-1:0], devict, hit};
    end
  end
endmodule

[verif/tb_set_assoc_lru_cache_model.sv]
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  localparam int unsigned Ways = 8;
  localparam int unsigned Sets = 256;
  localparam int unsigned NLines = Ways * Sets;
  localparam int unsigned WatchdogLimit = 20000;
  localparam logic OpRead = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef struct packed {
    logic [13:0] bytes_moved;
    logic [11:0] access_cycles;
    logic        dirty_evict;
    logic        hit;
  } result_t;

  // directed row: access, checked against a fixed result when check_fixed
  typedef struct {
    bit          check_fixed;
    logic        op;
    logic [31:0] addr;
    result_t     fixed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  set_assoc_lru_cache_model i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // cache shadow state
  bit          sh_valid [NLines];
  bit          sh_dirty [NLines];
  logic [31:0] sh_tag   [NLines];
  int unsigned sh_rank  [NLines];
  cfg_t        sh_cfg;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_mode = 1'b0;
  bit          timed_out = 1'b0;

  function automatic void age_set(int unsigned base, int unsigned w, int unsigned ways,
                                  int unsigned old);
    for (int unsigned i = 0; i < ways; i++) begin
      if (i != w && sh_valid[base+i] && sh_rank[base+i] < old && sh_rank[base+i] < Ways - 1)
        sh_rank[base+i]++;
    end
    sh_rank[base+w] = 0;
  endfunction

  function automatic result_t predict_access(logic op, logic [31:0] addr);
    int unsigned off, sib, ways, set_n, base, block, victim, k, old;
    logic [31:0] tag;
    logic [31:0] cycles, bytes;
    result_t r;
    off = sh_cfg.off_bits > MaxOffBits ? MaxOffBits : sh_cfg.off_bits;
    sib = sh_cfg.set_bits > MaxSetBits ? MaxSetBits : sh_cfg.set_bits;
    ways = sh_cfg.ways_used == 0 ? 1 : (sh_cfg.ways_used > Ways ? Ways : sh_cfg.ways_used);
    set_n = ((addr >> off) & ((32'd1 << sib) - 1)) % Sets;
    base = set_n * Ways;
    tag = (off + sib >= 32) ? 32'd0 : (addr >> (off + sib));
    block = 1 << off;
    cycles = sh_cfg.hit_time;
    bytes = 0;
    r = '0;
    victim = Ways;
    for (int unsigned w = 0; w < ways; w++) begin
      if (!r.hit && sh_valid[base+w] && sh_tag[base+w] == tag) begin
        r.hit = 1'b1;
        age_set(base, w, ways, sh_rank[base+w]);
        if (op == OpWrite) begin
          if (sh_cfg.wr_back) sh_dirty[base+w] = 1'b1;
          else begin
            bytes += sh_cfg.elem_size;
            cycles += sh_cfg.miss_penalty;
          end
        end
      end
    end
    if (!r.hit) begin
      cycles += sh_cfg.miss_penalty;
      if (op == OpWrite && !sh_cfg.write_alloc) begin
        bytes += sh_cfg.elem_size;
      end else begin
        for (int unsigned w = 0; w < ways; w++)
          if (victim == Ways && !sh_valid[base+w]) victim = w;
        if (victim == Ways) begin
          victim = 0;
          for (int unsigned w = 1; w < ways; w++)
            if (sh_rank[base+w] > sh_rank[base+victim]) victim = w;
        end
        k = base + victim;
        if (sh_valid[k] && sh_dirty[k]) begin
          r.dirty_evict = 1'b1;
          bytes += block;
          cycles += sh_cfg.miss_penalty;
        end
        bytes += block;
        old = sh_valid[k] ? sh_rank[k] : Ways;
        sh_valid[k] = 1'b1;
        sh_tag[k] = tag;
        age_set(base, victim, ways, old);
        if (op == OpWrite && !sh_cfg.wr_back) begin
          sh_dirty[k] = 1'b0;
          bytes += sh_cfg.elem_size;
          cycles += sh_cfg.miss_penalty;
        end else begin
          sh_dirty[k] = (op == OpWrite);
        end
      end
    end
    r.access_cycles = cycles[11:0];
    r.bytes_moved = bytes[13:0];
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet_mode && ($urandom_range(0, 99) < 8);
  endfunction

  // register write, block idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegOffBits:  sh_cfg.off_bits = value[3:0];
      RegSetBits:  sh_cfg.set_bits = value[3:0];
      RegWays:     sh_cfg.ways_used = value[3:0];
      RegWrBack:   sh_cfg.wr_back = value[0];
      RegWrAlloc:  sh_cfg.write_alloc = value[0];
      RegHitTime:  sh_cfg.hit_time = value[7:0];
      RegMissPen:  sh_cfg.miss_penalty = value[9:0];
      default:     sh_cfg.elem_size = value[6:0];
    endcase
  endtask

  task automatic set_config(int unsigned ob, int unsigned sb, int unsigned wu, bit wb,
                            bit wa, int unsigned ht, int unsigned mp, int unsigned es);
    write_reg(RegOffBits, ob);
    write_reg(RegSetBits, sb);
    write_reg(RegWays, wu);
    write_reg(RegWrBack, wb);
    write_reg(RegWrAlloc, wa);
    write_reg(RegHitTime, ht);
    write_reg(RegMissPen, mp);
    write_reg(RegElemSize, es);
  endtask

  // drive one item until accepted; tvalid stays high into a following item
  task automatic drive_item(logic op, logic [31:0] addr);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, addr, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // send one item; expectation queued before the accept edge
  task automatic send_access(logic op, logic [31:0] addr);
    pending_results.insert(pending_results.size(), predict_access(op, addr));
    drive_item(op, addr);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // result side
  always @(negedge clk_i) begin
    m_axis_tready <= !idle_now();
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[27:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[31:28] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0d de=%0d cyc=%0d bytes=%0d got hit=%0d de=%0d cyc=%0d bytes=%0d",
                     want.hit, want.dirty_evict, want.access_cycles, want.bytes_moved,
                     got.hit, got.dirty_evict, got.access_cycles, got.bytes_moved);
        end
      end
    end
  end

  // watchdog on accepted items and taken results
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WatchdogLimit + Sets) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    result_t got;
    int unsigned n;
    logic [31:0] hot[8];
    for (int i = 0; i < NLines; i++) begin
      sh_valid[i] = 0;
      sh_dirty[i] = 0;
      sh_tag[i] = '0;
      sh_rank[i] = 0;
    end
    sh_cfg = '{off_bits: 6, set_bits: 4, ways_used: 1, wr_back: 1, write_alloc: 1,
               hit_time: 1, miss_penalty: 50, elem_size: 1};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed at reset config: read miss, read hit, write hit, dirty eviction, then two predicted accesses
    rows.insert(rows.size(), row_t'{1, OpRead, 32'h0000_0000, '{64, 51, 1'b0, 1'b0}});
    rows.insert(rows.size(), row_t'{1, OpRead, 32'h0000_003f, '{0, 1, 1'b0, 1'b1}});
    rows.insert(rows.size(), row_t'{1, OpWrite, 32'h0000_0010, '{0, 1, 1'b0, 1'b1}});
    rows.insert(rows.size(), row_t'{1, OpRead, 32'h0000_0400, '{128, 101, 1'b1, 1'b0}});
    rows.insert(rows.size(), row_t'{0, OpWrite, 32'hffff_ffff, '0});
    rows.insert(rows.size(), row_t'{0, OpRead, 32'hffff_ffc0, '0});
    foreach (rows[i]) begin
      rw = rows[i];
      got = predict_access(rw.op, rw.addr);
      pending_results.insert(pending_results.size(), rw.check_fixed ? rw.fixed : got);
      // predictor kept in step; push the item without a second prediction
      drive_item(rw.op, rw.addr);
    end
    drain();

    // extremes: saturating offset/index, ways 0 and above range, write-through
    set_config(15, 15, 0, 0, 0, 255, 1023, 64);
    send_access(OpWrite, 32'h0000_0000);
    send_access(OpRead, 32'hffff_ffff);
    send_access(OpWrite, 32'hffff_f000);
    send_access(OpWrite, 32'h1234_5678);
    drain();
    set_config(0, 0, 15, 0, 1, 0, 0, 1);
    for (int i = 0; i < 10; i++) send_access(i[0], 32'(i * 3));
    drain();
    // lower ways at run time, then dirty eviction in write-through mode
    set_config(4, 2, 8, 1, 1, 3, 7, 5);
    for (int i = 0; i < 10; i++) send_access(OpWrite, 32'(i << 6));
    drain();
    write_reg(RegWays, 2);
    write_reg(RegWrBack, 0);
    for (int i = 0; i < 5; i++) send_access(i[0], 32'((i + 20) << 6));
    drain();

    // random phases: hot addresses give hits and reuse
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0 || ph == 6)
        set_config(0, 0, 1, ph[0], 1, 0, 0, 1);
      else
        set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(1, 64));
      if (ph == 3) set_config(12, 8, 8, 1, 1, 255, 1023, 64);
      quiet_mode = (ph == 2);
      foreach (hot[i]) hot[i] = $urandom();
      n = 100;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) != 0)
          send_access(1'($urandom_range(0, 1)), hot[$urandom_range(0, 7)]
                      ^ $urandom_range(0, 3) ^ (32'($urandom_range(0, 3)) << 12));
        else
          send_access(1'($urandom_range(0, 1)), $urandom());
      end
      drain();
    end
    quiet_mode = 1'b0;
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[set_assoc_lru_cache_model.f]
sv/salc_pkg.sv
sv/salc_cfg_regs.sv
sv/set_assoc_lru_cache_model.sv
verif/tb_set_assoc_lru_cache_model.sv
